@@ src/cmcm_pkg.sv @@
// Shared types, constants and helper functions of the control macro curve mapper.
package cmcm_pkg;

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_WALK,
        ST_REMOVE
    } state_t;

    localparam logic [2:0] ACT_ADD    = 3'd0;
    localparam logic [2:0] ACT_TARGET = 3'd1;
    localparam logic [2:0] ACT_REMOVE = 3'd2;
    localparam logic [2:0] ACT_QUERY  = 3'd3;
    localparam logic [2:0] ACT_EVENT  = 3'd4;

    localparam logic [1:0] CURVE_LINEAR = 2'd0;
    localparam logic [1:0] CURVE_SQUARE = 2'd1;
    localparam logic [1:0] CURVE_LOG    = 2'd2;

    localparam logic [16:0] ONE_Q16 = 17'd65536;

    localparam int WORD_W   = 40;
    localparam int IN_DATA_W  = 120;
    localparam int IN_USER_W  = 3;
    localparam int OUT_DATA_W = 64;

    // target word layout
    localparam int W_CC_LSB    = 0;
    localparam int W_CURVE_LSB = 7;
    localparam int W_INV_BIT   = 9;
    localparam int W_SCALE_LSB = 10;
    localparam int W_MIN_LSB   = 26;
    localparam int W_MAX_LSB   = 33;

    typedef struct packed
    {
        logic [15:0] macro_id;
        logic        last;
    } tag_t;

    function automatic logic [16:0] log_rom(input logic [4:0] idx);
        logic [16:0] v;
        case (idx)
            5'd0:    v = 17'd0;
            5'd1:    v = 17'd6685;
            5'd2:    v = 17'd12751;
            5'd3:    v = 17'd18303;
            5'd4:    v = 17'd23421;
            5'd5:    v = 17'd28168;
            5'd6:    v = 17'd32594;
            5'd7:    v = 17'd36740;
            5'd8:    v = 17'd40640;
            5'd9:    v = 17'd44320;
            5'd10:   v = 17'd47805;
            5'd11:   v = 17'd51113;
            5'd12:   v = 17'd54263;
            5'd13:   v = 17'd57268;
            5'd14:   v = 17'd60142;
            5'd15:   v = 17'd62894;
            5'd16:   v = 17'd65536;
            default: v = 17'd65536;
        endcase
        return v;
    endfunction

    // floor((v * 65536 + 2047) / 4095) as 16v + floor((16v + 2047) / 4095)
    function automatic logic [16:0] norm_of(input logic [11:0] v);
        logic [16:0] x;
        logic [4:0]  q0;
        logic [16:0] r;
        logic [4:0]  q;
        x  = {1'b0, v, 4'b0} + 17'd2047;
        q0 = x[16:12];
        r  = x - {q0[4:0], 12'b0} + {12'b0, q0};
        q  = (r >= 17'd4095) ? q0 + 5'd1 : q0;
        return {1'b0, v, 4'b0} + {12'b0, q};
    endfunction

endpackage

@@ src/control_macro_curve_mapper_core.sv @@
// Top level of the control macro curve mapper: macro list control and result output.
// Add, target add and query are acknowledged via the acknowledgment and output registers.
// Remove walks the macro list, one macro per cycle, and acknowledges once the walk ends
// (at once for an empty list). A control event walks the list while the output is not
// stalled, one non-matching macro per cycle; a matching macro issues one target read
// from the target memory per cycle, and each read yields one result through the memory
// read, three mapping stages and the output register. A new item is accepted once the
// mapping pipeline has drained; stalls on the result side stall the whole walk.
// No clearing pass runs after reset.
module control_macro_curve_mapper_core #(
    parameter int MAX_MACROS  = 8,
    parameter int MAX_TARGETS = 8
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // control_key, macro_key, control_value, event_time, target_cc, target_curve,
    // target_invert, target_scale, target_min, target_max, zero pad
    input  logic [cmcm_pkg::IN_DATA_W-1:0]   s_tdata,
    // action
    input  logic [cmcm_pkg::IN_USER_W-1:0]   s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // dropped, found, out_macro, out_cc, out_value, out_time
    output logic [cmcm_pkg::OUT_DATA_W-1:0]  m_tdata,
    // result_kind
    output logic                             m_tuser,
    output logic                             m_tlast
);
    import cmcm_pkg::*;

    localparam int SW    = (MAX_MACROS > 1) ? $clog2(MAX_MACROS) : 1;
    localparam int CW    = $clog2(MAX_MACROS + 1);
    localparam int TW    = $clog2(MAX_TARGETS + 1);
    localparam int TIW   = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1;
    localparam int DEPTH = MAX_MACROS * MAX_TARGETS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    state_t state_reg, state_next;

    logic [CW-1:0]         list_cnt_reg, list_cnt_next;
    logic [MAX_MACROS-1:0] used_reg, used_next;
    logic [SW-1:0]         order_reg [MAX_MACROS];
    logic [SW-1:0]         order_next [MAX_MACROS];
    logic [15:0]           src_reg [MAX_MACROS];
    logic [15:0]           src_next [MAX_MACROS];
    logic [15:0]           id_reg [MAX_MACROS];
    logic [15:0]           id_next [MAX_MACROS];
    logic [TW-1:0]         tcnt_reg [MAX_MACROS];
    logic [TW-1:0]         tcnt_next [MAX_MACROS];

    logic [15:0]  key_reg, key_next;
    logic [16:0]  norm_reg, norm_next;
    logic [31:0]  time_reg, time_next;
    logic [SW-1:0] k_reg, k_next;
    logic [TIW-1:0] t_reg, t_next;
    logic [CW-1:0] keep_reg, keep_next;

    logic        ack_valid_reg, ack_valid_next;
    logic        ack_drop_reg, ack_drop_next;
    logic        ack_found_reg, ack_found_next;
    logic [15:0] ack_macro_reg, ack_macro_next;
    logic [6:0]  ack_cc_reg, ack_cc_next;

    logic        rd_valid_reg;
    tag_t        rd_tag_reg;

    logic        out_valid_reg;
    logic        out_kind_reg, out_drop_reg, out_found_reg, out_last_reg;
    logic [15:0] out_macro_reg;
    logic [6:0]  out_cc_reg, out_value_reg;
    logic [31:0] out_time_reg;

    logic        adv, accept;
    logic [2:0]  in_action;
    logic [15:0] in_ckey, in_mkey;
    logic [11:0] in_cval;
    logic [31:0] in_time;
    logic [6:0]  in_cc;
    logic [WORD_W-1:0] in_word;

    logic [SW-1:0] free_slot, cur_slot, last_slot;
    logic          any_src, any_evt, later_match, cur_match, cur_last_t, walk_last;
    logic          ram_we, rd_issue;
    logic [AW-1:0] ram_waddr, rd_addr;
    tag_t          rd_tag;
    logic [WORD_W-1:0] ram_rdata;

    logic        pipe_valid, pipe_busy;
    tag_t        pipe_tag;
    logic [6:0]  pipe_cc, pipe_value;

    assign in_action = s_tuser[2:0];
    assign in_ckey   = s_tdata[15:0];
    assign in_mkey   = s_tdata[31:16];
    assign in_cval   = s_tdata[43:32];
    assign in_time   = s_tdata[75:44];
    assign in_cc     = s_tdata[82:76];
    assign in_word   = {s_tdata[115:109], s_tdata[108:102], s_tdata[101:86],
                        s_tdata[85], s_tdata[84:83], s_tdata[82:76]};

    assign adv      = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && !ack_valid_reg && !rd_valid_reg && !pipe_busy;
    assign accept   = s_tvalid && s_tready;

    assign cur_slot   = order_reg[k_reg];
    assign last_slot  = order_reg[SW'(list_cnt_reg - CW'(1))];
    assign cur_match  = (src_reg[cur_slot] == key_reg) && (tcnt_reg[cur_slot] != '0);
    assign cur_last_t = (TW'(t_reg) + TW'(1)) == tcnt_reg[cur_slot];
    assign walk_last  = cur_last_t && !later_match;

    always_comb
    begin
        free_slot = '0;
        for (int i = MAX_MACROS - 1; i >= 0; i--)
        begin
            if (!used_reg[i])
            begin
                free_slot = SW'(i);
            end
        end
        any_src = 1'b0;
        any_evt = 1'b0;
        for (int i = 0; i < MAX_MACROS; i++)
        begin
            if (used_reg[i] && src_reg[i] == in_ckey)
            begin
                any_src = 1'b1;
                if (tcnt_reg[i] != '0)
                begin
                    any_evt = 1'b1;
                end
            end
        end
        later_match = 1'b0;
        for (int j = 0; j < MAX_MACROS; j++)
        begin
            if (SW'(j) > k_reg && CW'(j) < list_cnt_reg
                && src_reg[order_reg[j]] == key_reg && tcnt_reg[order_reg[j]] != '0)
            begin
                later_match = 1'b1;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && in_action == ACT_EVENT && any_evt)
                begin
                    state_next = ST_WALK;
                end
                else if (accept && in_action == ACT_REMOVE && list_cnt_reg != '0)
                begin
                    state_next = ST_REMOVE;
                end
            end
            ST_WALK:
            begin
                if (adv && cur_match && walk_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_REMOVE:
            begin
                if ((CW'(k_reg) + CW'(1)) == list_cnt_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        list_cnt_next  = list_cnt_reg;
        used_next      = used_reg;
        order_next     = order_reg;
        src_next       = src_reg;
        id_next        = id_reg;
        tcnt_next      = tcnt_reg;
        key_next       = key_reg;
        norm_next      = norm_reg;
        time_next      = time_reg;
        k_next         = k_reg;
        t_next         = t_reg;
        keep_next      = keep_reg;
        ack_valid_next = ack_valid_reg;
        ack_drop_next  = ack_drop_reg;
        ack_found_next = ack_found_reg;
        ack_macro_next = ack_macro_reg;
        ack_cc_next    = ack_cc_reg;
        ram_we         = 1'b0;
        ram_waddr      = '0;
        rd_issue       = 1'b0;
        rd_addr        = '0;
        rd_tag         = '0;

        if (adv && ack_valid_reg && !pipe_valid)
        begin
            ack_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    ack_drop_next  = 1'b0;
                    ack_found_next = 1'b0;
                    ack_macro_next = '0;
                    ack_cc_next    = '0;
                    k_next         = '0;
                    t_next         = '0;
                    keep_next      = '0;
                    case (in_action)
                        ACT_ADD:
                        begin
                            ack_valid_next = 1'b1;
                            ack_macro_next = in_mkey;
                            if (list_cnt_reg >= CW'(MAX_MACROS))
                            begin
                                ack_drop_next = 1'b1;
                            end
                            else
                            begin
                                src_next[free_slot]   = in_ckey;
                                id_next[free_slot]    = in_mkey;
                                tcnt_next[free_slot]  = '0;
                                used_next[free_slot]  = 1'b1;
                                order_next[SW'(list_cnt_reg)] = free_slot;
                                list_cnt_next = list_cnt_reg + CW'(1);
                            end
                        end
                        ACT_TARGET:
                        begin
                            ack_valid_next = 1'b1;
                            ack_cc_next    = in_cc;
                            if (list_cnt_reg == '0)
                            begin
                                ack_drop_next = 1'b1;
                            end
                            else
                            begin
                                ack_macro_next = id_reg[last_slot];
                                if (tcnt_reg[last_slot] >= TW'(MAX_TARGETS))
                                begin
                                    ack_drop_next = 1'b1;
                                end
                                else
                                begin
                                    ram_we    = 1'b1;
                                    ram_waddr = AW'(last_slot) * AW'(MAX_TARGETS)
                                              + AW'(tcnt_reg[last_slot]);
                                    tcnt_next[last_slot] = tcnt_reg[last_slot] + TW'(1);
                                end
                            end
                        end
                        ACT_REMOVE:
                        begin
                            key_next       = in_mkey;
                            ack_macro_next = in_mkey;
                            if (list_cnt_reg == '0)
                            begin
                                ack_valid_next = 1'b1;
                            end
                        end
                        ACT_QUERY:
                        begin
                            ack_valid_next = 1'b1;
                            ack_found_next = any_src;
                        end
                        ACT_EVENT:
                        begin
                            key_next  = in_ckey;
                            norm_next = norm_of(in_cval);
                            time_next = in_time;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_WALK:
            begin
                if (adv)
                begin
                    if (!cur_match)
                    begin
                        k_next = k_reg + SW'(1);
                    end
                    else
                    begin
                        rd_issue        = 1'b1;
                        rd_addr         = AW'(cur_slot) * AW'(MAX_TARGETS) + AW'(t_reg);
                        rd_tag.macro_id = id_reg[cur_slot];
                        rd_tag.last     = walk_last;
                        if (cur_last_t)
                        begin
                            t_next = '0;
                            k_next = k_reg + SW'(1);
                        end
                        else
                        begin
                            t_next = t_reg + TIW'(1);
                        end
                    end
                end
            end
            ST_REMOVE:
            begin
                if (id_reg[cur_slot] == key_reg)
                begin
                    used_next[cur_slot] = 1'b0;
                end
                else
                begin
                    order_next[SW'(keep_reg)] = cur_slot;
                    keep_next = keep_reg + CW'(1);
                end
                if ((CW'(k_reg) + CW'(1)) == list_cnt_reg)
                begin
                    list_cnt_next  = keep_next;
                    ack_valid_next = 1'b1;
                end
                else
                begin
                    k_next = k_reg + SW'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            list_cnt_reg  <= '0;
            used_reg      <= '0;
            ack_valid_reg <= 1'b0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            list_cnt_reg  <= list_cnt_next;
            used_reg      <= used_next;
            ack_valid_reg <= ack_valid_next;
            if (adv)
            begin
                rd_valid_reg  <= rd_issue;
                out_valid_reg <= pipe_valid || ack_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        order_reg     <= order_next;
        src_reg       <= src_next;
        id_reg        <= id_next;
        tcnt_reg      <= tcnt_next;
        key_reg       <= key_next;
        norm_reg      <= norm_next;
        time_reg      <= time_next;
        k_reg         <= k_next;
        t_reg         <= t_next;
        keep_reg      <= keep_next;
        ack_drop_reg  <= ack_drop_next;
        ack_found_reg <= ack_found_next;
        ack_macro_reg <= ack_macro_next;
        ack_cc_reg    <= ack_cc_next;
        if (adv)
        begin
            rd_tag_reg <= rd_tag;
            if (pipe_valid)
            begin
                out_kind_reg  <= 1'b1;
                out_drop_reg  <= 1'b0;
                out_found_reg <= 1'b0;
                out_macro_reg <= pipe_tag.macro_id;
                out_cc_reg    <= pipe_cc;
                out_value_reg <= pipe_value;
                out_time_reg  <= time_reg;
                out_last_reg  <= pipe_tag.last;
            end
            else
            begin
                out_kind_reg  <= 1'b0;
                out_drop_reg  <= ack_drop_reg;
                out_found_reg <= ack_found_reg;
                out_macro_reg <= ack_macro_reg;
                out_cc_reg    <= ack_cc_reg;
                out_value_reg <= '0;
                out_time_reg  <= '0;
                out_last_reg  <= 1'b1;
            end
        end
    end

    cmcm_target_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (in_word),
        .re    (adv),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    cmcm_curve_pipe u_pipe (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (rd_valid_reg),
        .in_tag    (rd_tag_reg),
        .word      (ram_rdata),
        .norm      (norm_reg),
        .out_valid (pipe_valid),
        .out_tag   (pipe_tag),
        .out_cc    (pipe_cc),
        .out_value (pipe_value),
        .busy      (pipe_busy)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {out_time_reg, out_value_reg, out_cc_reg, out_macro_reg,
                       out_found_reg, out_drop_reg};

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        list_cnt_reg <= CW'(MAX_MACROS))
        else $error("macro count exceeds list size");

    a_ack_vs_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        !(ack_valid_reg && pipe_valid))
        else $error("acknowledgment collides with mapped result");

    a_used_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> $countones(used_reg) == int'(list_cnt_reg))
        else $error("slot usage disagrees with macro count");

    a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> state_reg == ST_IDLE && !rd_valid_reg)
        else $error("target write during walk");
`endif

endmodule

@@ src/cmcm_target_ram.sv @@
// Target word memory: one write port, one registered read port.
module cmcm_target_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                       clk,
    input  logic                       we,
    input  logic [AW-1:0]              waddr,
    input  logic [cmcm_pkg::WORD_W-1:0] wdata,
    input  logic                       re,
    input  logic [AW-1:0]              raddr,
    output logic [cmcm_pkg::WORD_W-1:0] rdata
);
    import cmcm_pkg::*;

    logic [WORD_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ src/cmcm_curve_pipe.sv @@
// Three-stage curve, invert, scale and range mapping pipeline for one target.
module cmcm_curve_pipe (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  cmcm_pkg::tag_t              in_tag,
    input  logic [cmcm_pkg::WORD_W-1:0] word,
    input  logic [16:0]                 norm,
    output logic                        out_valid,
    output cmcm_pkg::tag_t              out_tag,
    output logic [6:0]                  out_cc,
    output logic [6:0]                  out_value,
    output logic                        busy
);
    import cmcm_pkg::*;

    logic               a_v_reg, b_v_reg, c_v_reg;
    tag_t               a_tag_reg, b_tag_reg, c_tag_reg;
    logic [WORD_W-1:0]  a_word_reg, b_word_reg;
    logic [33:0]        a_prod_reg;
    logic [16:0]        a_base_reg;
    logic [1:0]         a_mode_reg;
    logic               a_full_reg;
    logic [32:0]        b_prod_reg;
    logic signed [25:0] c_prod_reg;
    logic [6:0]         c_min_reg, c_cc_reg;

    logic [1:0]  curve;
    logic [4:0]  idx;
    logic [16:0] rom_lo, rom_hi, rom_diff, mul_x, mul_y, a_base_next;
    logic [33:0] a_prod_next;
    logic [33:0] sq_sum, lg_sum;
    logic [16:0] curved, inv_val;
    logic [32:0] b_prod_next;
    logic [33:0] b_sum;
    logic [21:0] sh;
    logic [16:0] sat;
    logic signed [7:0]  span;
    logic signed [25:0] c_prod_next;
    logic signed [26:0] total;

    always_comb
    begin
        curve    = word[W_CURVE_LSB +: 2];
        idx      = norm[16:12];
        rom_lo   = log_rom(idx);
        rom_hi   = log_rom(idx + 5'd1);
        rom_diff = rom_hi - rom_lo;
        if (curve == CURVE_SQUARE)
        begin
            mul_x = norm;
            mul_y = norm;
        end
        else
        begin
            mul_x = rom_diff;
            mul_y = {5'b0, norm[11:0]};
        end
        a_prod_next = mul_x * mul_y;
        a_base_next = (curve == CURVE_LOG) ? rom_lo : norm;
    end

    always_comb
    begin
        sq_sum = a_prod_reg + 34'd32768;
        lg_sum = a_prod_reg + 34'd2048;
        case (a_mode_reg)
            CURVE_SQUARE: curved = sq_sum[32:16];
            CURVE_LOG:    curved = a_full_reg ? ONE_Q16 : a_base_reg + lg_sum[28:12];
            default:      curved = a_base_reg;
        endcase
        inv_val     = a_word_reg[W_INV_BIT] ? ONE_Q16 - curved : curved;
        b_prod_next = inv_val * a_word_reg[W_SCALE_LSB +: 16];
    end

    always_comb
    begin
        b_sum       = {1'b0, b_prod_reg} + 34'd2048;
        sh          = b_sum[33:12];
        sat         = (sh > 22'd65536) ? ONE_Q16 : sh[16:0];
        span        = $signed({1'b0, b_word_reg[W_MAX_LSB +: 7]})
                    - $signed({1'b0, b_word_reg[W_MIN_LSB +: 7]});
        c_prod_next = 26'($signed({1'b0, sat}) * span);
    end

    always_comb
    begin
        total = $signed({4'b0, c_min_reg, 16'b0}) + 27'(c_prod_reg) + 27'sd32768;
        if (total < 0)
        begin
            total = '0;
        end
        out_value = total[22:16];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
            c_v_reg <= 1'b0;
        end
        else if (en)
        begin
            a_v_reg <= in_valid;
            b_v_reg <= a_v_reg;
            c_v_reg <= b_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_tag_reg  <= in_tag;
            a_word_reg <= word;
            a_prod_reg <= a_prod_next;
            a_base_reg <= a_base_next;
            a_mode_reg <= curve;
            a_full_reg <= idx[4];
            b_tag_reg  <= a_tag_reg;
            b_word_reg <= a_word_reg;
            b_prod_reg <= b_prod_next;
            c_tag_reg  <= b_tag_reg;
            c_prod_reg <= c_prod_next;
            c_min_reg  <= b_word_reg[W_MIN_LSB +: 7];
            c_cc_reg   <= b_word_reg[W_CC_LSB +: 7];
        end
    end

    assign out_valid = c_v_reg;
    assign out_tag   = c_tag_reg;
    assign out_cc    = c_cc_reg;
    assign busy      = a_v_reg | b_v_reg | c_v_reg;

endmodule
